// ===== rtl/gpioirq_pkg.sv =====
// Shared transaction types and operation codes for the GPIO controller with interrupt groups.
package gpioirq_pkg;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] addr;
      logic [31:0] wdata;
      logic [63:0] pad_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic        addr_error;
      logic [7:0]  irq_lines;
      logic [63:0] pad_out;
      logic [63:0] pad_oe;
      logic [63:0] pad_periph;
   } rsp_type;

endpackage

// ===== rtl/gpio_controller_with_irq_groups.sv =====
// GPIO controller: per-pin configuration, grouped edge and level interrupts.
//
// Usage: every request transaction is a bus read, a bus write, a sample of
// the pad levels or a no-op (code 3), and each one produces exactly one response transaction.
// Pin words sit at 4*pin; pending words at 0x800 + 0x40*group + 4*word, and
// writing ones to a pending word clears those bits. The response carries the
// read data, an address error flag, and the interrupt lines and pad controls
// as they stand after the request has taken effect.
//
// A request updates the state and loads the response register at the clock
// edge that accepts it. Throughput is one request per cycle while the
// receiver takes each response; all decode, sampling and read-mux logic sits
// between the state registers and the response register.
// The response register is the only buffer: while a response waits, a new
// request is taken in the same cycle that the response is taken, so a
// stalled receiver holds off the requester and the response stays stable.
// Reset clears every pin word, all pending bits and the last sampled levels,
// and drops the response valid.
module gpio_controller_with_irq_groups #(
   parameter int PIN_COUNT  = 64,
   parameter int IRQ_GROUPS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  gpioirq_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gpioirq_pkg::rsp_type rsp_data
);
   import gpioirq_pkg::*;

   localparam int PIN_IDX_W       = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int GRP_IDX_W       = (IRQ_GROUPS > 1) ? $clog2(IRQ_GROUPS) : 1;
   localparam int WORDS_PER_GROUP = (PIN_COUNT + 31) / 32;

   localparam logic [2:0] MODE_OUTPUT     = 3'd1;
   localparam logic [2:0] MODE_LEVEL_HIGH = 3'd2;
   localparam logic [2:0] MODE_LEVEL_LOW  = 3'd3;
   localparam logic [2:0] MODE_RISING     = 3'd4;
   localparam logic [2:0] MODE_FALLING    = 3'd5;
   localparam logic [2:0] MODE_ANY_EDGE   = 3'd6;

   typedef struct packed {
      logic [2:0] group;
      logic       done;
      logic       periph;
      logic [2:0] mode;
      logic       out_data;
   } pin_cfg_type;

   function automatic logic pin_fires(logic [2:0] mode, logic now, logic prev);
      logic hit;
      hit = 1'b0;
      case (mode)
         MODE_LEVEL_HIGH: hit = now;
         MODE_LEVEL_LOW:  hit = !now;
         MODE_RISING:     hit = now && !prev;
         MODE_FALLING:    hit = !now && prev;
         MODE_ANY_EDGE:   hit = now != prev;
         default:         hit = 1'b0;
      endcase
      return hit;
   endfunction

   pin_cfg_type            cfg_ff  [PIN_COUNT];
   pin_cfg_type            cfg_in  [PIN_COUNT];
   logic [PIN_COUNT-1:0]   pend_ff [IRQ_GROUPS];
   logic [PIN_COUNT-1:0]   pend_in [IRQ_GROUPS];
   logic [PIN_COUNT-1:0]   last_ff;
   logic [PIN_COUNT-1:0]   last_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [31:0]            rdata_ff;
   logic [31:0]            rdata_in;
   logic                   err_ff;
   logic                   err_in;

   logic                   accept;
   logic                   aligned;
   logic [8:0]             pin_num;
   logic [4:0]             grp_num;
   logic [3:0]             word_num;
   logic                   pin_hit;
   logic                   pend_hit;
   logic [PIN_IDX_W-1:0]   pin_idx;
   logic [GRP_IDX_W-1:0]   grp_idx;
   pin_cfg_type            rd_cfg;
   logic [63:0]            pend_wide;
   logic [63:0]            clear_wide;
   logic [2:0]             smp_group;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Address decode for bus transactions.
   always_comb begin
      aligned  = req_data.addr[1:0] == 2'b00;
      pin_num  = req_data.addr[10:2];
      grp_num  = req_data.addr[10:6];
      word_num = req_data.addr[5:2];
      pin_hit  = aligned && !req_data.addr[11] && (pin_num < 9'(PIN_COUNT));
      pend_hit = aligned && req_data.addr[11] && (grp_num < 5'(IRQ_GROUPS))
                 && (word_num < 4'(WORDS_PER_GROUP));
      pin_idx  = pin_num[PIN_IDX_W-1:0];
      grp_idx  = grp_num[GRP_IDX_W-1:0];
      rd_cfg   = cfg_ff[pin_idx];
      pend_wide  = 64'(pend_ff[grp_idx]);
      clear_wide = req_data.addr[2] ? {req_data.wdata, 32'h0} : {32'h0, req_data.wdata};
   end

   always_comb begin
      cfg_in       = cfg_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      rdata_in     = '0;
      err_in       = 1'b0;
      smp_group    = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         unique case (req_data.op)
            OP_READ: begin
               if (pin_hit) begin
                  rdata_in = {13'h0, rd_cfg.group, 6'h0, rd_cfg.done, 3'h0, rd_cfg.periph,
                              1'b0, rd_cfg.mode, last_ff[pin_idx]};
               end else if (pend_hit) begin
                  rdata_in = req_data.addr[2] ? pend_wide[63:32] : pend_wide[31:0];
               end else begin
                  err_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (pin_hit) begin
                  cfg_in[pin_idx] = '{group:    req_data.wdata[18:16],
                                      done:     req_data.wdata[9],
                                      periph:   req_data.wdata[5],
                                      mode:     req_data.wdata[3:1],
                                      out_data: req_data.wdata[0]};
               end else if (pend_hit) begin
                  pend_in[grp_idx] = pend_ff[grp_idx] & ~clear_wide[PIN_COUNT-1:0];
               end else begin
                  err_in = 1'b1;
               end
            end
            OP_SAMPLE: begin
               for (int p = 0; p < PIN_COUNT; p++) begin
                  smp_group = cfg_ff[p].group;
                  if ((4'(smp_group) < 4'(IRQ_GROUPS)) &&
                      pin_fires(cfg_ff[p].mode, req_data.pad_levels[p], last_ff[p])) begin
                     pend_in[smp_group[GRP_IDX_W-1:0]][p] = 1'b1;
                  end
               end
               last_in = req_data.pad_levels[PIN_COUNT-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         for (int p = 0; p < PIN_COUNT; p++) begin
            cfg_ff[p] <= '0;
         end
         for (int g = 0; g < IRQ_GROUPS; g++) begin
            pend_ff[g] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         cfg_ff       <= cfg_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rdata_ff <= rdata_in;
         err_ff   <= err_in;
      end
   end

   // State only changes when a new response is loaded, so the status fields
   // can be taken straight from the state registers.
   always_comb begin
      rsp_data            = '0;
      rsp_data.rdata      = rdata_ff;
      rsp_data.addr_error = err_ff;
      for (int g = 0; g < IRQ_GROUPS; g++) begin
         rsp_data.irq_lines[g] = |pend_ff[g];
      end
      for (int p = 0; p < PIN_COUNT; p++) begin
         rsp_data.pad_out[p]    = cfg_ff[p].out_data;
         rsp_data.pad_periph[p] = cfg_ff[p].periph;
         rsp_data.pad_oe[p]     = !cfg_ff[p].periph && (cfg_ff[p].mode == MODE_OUTPUT);
      end
   end

endmodule

// ===== rtl/gpioirq_checker.sv =====
// Port-level assertions for the GPIO controller, bound to the top level.
module gpioirq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input gpioirq_pkg::req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input gpioirq_pkg::rsp_type rsp_data
);
   import gpioirq_pkg::*;

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A write transaction answers in the next cycle with zero read data.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.op == OP_WRITE)
      |=> rsp_valid && (rsp_data.rdata == 32'h0))
      else $error("write response missing or carries read data");

   // A sample never reports an address error.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.op == OP_SAMPLE)
      |=> rsp_valid && !rsp_data.addr_error)
      else $error("sample response flagged an address error");

   // Misaligned bus accesses fail and return zero.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_data.op == OP_READ) || (req_data.op == OP_WRITE))
      && (req_data.addr[1:0] != 2'b00)
      |=> rsp_data.addr_error && (rsp_data.rdata == 32'h0))
      else $error("misaligned access not rejected");

   // A pin handed to the peripheral is never driven as a GPIO output.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.pad_oe & rsp_data.pad_periph) == 64'h0))
      else $error("output enable set on a peripheral pin");

endmodule

bind gpio_controller_with_irq_groups gpioirq_checker u_gpioirq_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the GPIO controller with grouped interrupts.
`timescale 1ns / 100ps

module tb;
   import gpioirq_pkg::*;

   localparam int PINS            = 64;
   localparam int GROUPS          = 8;
   localparam int WORDS_PER_GROUP = (PINS + 31) / 32;
   localparam int PEND_BASE       = 'h800;
   localparam int PEND_STRIDE     = 'h40;
   localparam logic [31:0] CFG_KEEP = 32'h0007_022F;
   localparam logic [1:0]  OP_NONE  = 2'd3;

   localparam logic [2:0] MODE_OUTPUT     = 3'd1;
   localparam logic [2:0] MODE_LEVEL_HIGH = 3'd2;
   localparam logic [2:0] MODE_LEVEL_LOW  = 3'd3;
   localparam logic [2:0] MODE_RISE       = 3'd4;
   localparam logic [2:0] MODE_FALL       = 3'd5;
   localparam logic [2:0] MODE_ANY_EDGE   = 3'd6;

   localparam int RANDOM_PER_PHASE = 382;
   localparam int CYCLE_LIMIT      = 200000;

   typedef struct packed {
      req_type     item;
      logic        typed;
      logic [31:0] rdata;
      logic        err;
   } gpio_case_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Shadow of the block's state.
   logic [31:0] pin_cfg [PINS];
   logic [31:0] pend_word [GROUPS * WORDS_PER_GROUP];
   logic [63:0] last_lv;

   rsp_type       awaited_rsp [$];
   rsp_type       want_rsp;
   gpio_case_type directed_rows [$];
   logic          fixed_check = 1'b0;
   logic [31:0]   fixed_rdata = '0;
   logic          fixed_err = 1'b0;
   logic [63:0]   prev_levels = '0;
   int unsigned   send_idle_pct = 0;
   int unsigned   rsp_stall_pct = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;

   gpio_controller_with_irq_groups #(
      .PIN_COUNT (PINS),
      .IRQ_GROUPS(GROUPS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Applies one transaction to the shadow state and returns the response it causes.
   function automatic rsp_type apply_gpio_item(input req_type r);
      rsp_type     o;
      int unsigned a, pin, grp, wd, p;
      logic [2:0]  md;
      logic        now_lv, old_lv, fire;
      o = '0;
      a = 32'(r.addr);
      case (r.op)
         OP_READ, OP_WRITE: begin
            if (a % 4 != 0) begin
               o.addr_error = 1'b1;
            end else if (a < PEND_BASE) begin
               pin = a / 4;
               if (pin >= PINS) begin
                  o.addr_error = 1'b1;
               end else if (r.op == OP_WRITE) begin
                  pin_cfg[pin] = r.wdata & CFG_KEEP;
               end else begin
                  o.rdata = {pin_cfg[pin][31:1], last_lv[pin]};
               end
            end else begin
               grp = (a - PEND_BASE) / PEND_STRIDE;
               wd  = ((a - PEND_BASE) % PEND_STRIDE) / 4;
               if (grp >= GROUPS || wd >= WORDS_PER_GROUP) begin
                  o.addr_error = 1'b1;
               end else if (r.op == OP_WRITE) begin
                  pend_word[grp * WORDS_PER_GROUP + wd] &= ~r.wdata;
               end else begin
                  o.rdata = pend_word[grp * WORDS_PER_GROUP + wd];
               end
            end
         end
         OP_SAMPLE: begin
            for (p = 0; p < PINS; p++) begin
               md     = pin_cfg[p][3:1];
               grp    = 32'(pin_cfg[p][18:16]);
               now_lv = r.pad_levels[p];
               old_lv = last_lv[p];
               case (md)
                  MODE_LEVEL_HIGH: fire = now_lv;
                  MODE_LEVEL_LOW:  fire = !now_lv;
                  MODE_RISE:       fire = now_lv && !old_lv;
                  MODE_FALL:       fire = !now_lv && old_lv;
                  MODE_ANY_EDGE:   fire = now_lv != old_lv;
                  default:         fire = 1'b0;
               endcase
               if (fire && grp < GROUPS) begin
                  pend_word[grp * WORDS_PER_GROUP + p / 32][p % 32] = 1'b1;
               end
            end
            last_lv = r.pad_levels;
         end
         default: ;
      endcase
      for (p = 0; p < GROUPS; p++) begin
         for (wd = 0; wd < WORDS_PER_GROUP; wd++) begin
            if (pend_word[p * WORDS_PER_GROUP + wd] != '0) o.irq_lines[p] = 1'b1;
         end
      end
      for (p = 0; p < PINS; p++) begin
         o.pad_out[p]    = pin_cfg[p][0];
         o.pad_periph[p] = pin_cfg[p][5];
         o.pad_oe[p]     = !pin_cfg[p][5] && pin_cfg[p][3:1] == MODE_OUTPUT;
      end
      return o;
   endfunction

   function automatic gpio_case_type dir_row(input logic [1:0] op, input logic [11:0] addr,
                                             input logic [31:0] wdata, input logic [63:0] lv,
                                             input logic typed, input logic [31:0] rd,
                                             input logic err);
      gpio_case_type c;
      c.item.op         = op;
      c.item.addr       = addr;
      c.item.wdata      = wdata;
      c.item.pad_levels = lv;
      c.typed           = typed;
      c.rdata           = rd;
      c.err             = err;
      return c;
   endfunction

   // Mostly well-formed traffic: pin setup, samples near the previous levels,
   // register reads and pending clears, with some stray accesses mixed in.
   function automatic req_type draw_gpio_item();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(99);
      r.op         = OP_READ;
      r.addr       = 12'($urandom_range(4095));
      r.wdata      = $urandom();
      r.pad_levels = {$urandom(), $urandom()};
      if (pick < 25) begin
         r.op   = OP_WRITE;
         r.addr = 12'($urandom_range(PINS - 1) * 4);
      end else if (pick < 55) begin
         r.op = OP_SAMPLE;
         case ($urandom_range(9))
            0:       r.pad_levels = '0;
            1:       r.pad_levels = '1;
            2, 3, 4: ;
            default: r.pad_levels = prev_levels ^ (64'd1 << $urandom_range(63))
                                                ^ (64'd1 << $urandom_range(63));
         endcase
         prev_levels = r.pad_levels;
      end else if (pick < 70) begin
         r.addr = 12'($urandom_range(PINS - 1) * 4);
      end else if (pick < 80) begin
         r.addr = 12'(PEND_BASE + $urandom_range(GROUPS - 1) * PEND_STRIDE
                      + $urandom_range(WORDS_PER_GROUP - 1) * 4);
      end else if (pick < 88) begin
         r.op   = OP_WRITE;
         r.addr = 12'(PEND_BASE + $urandom_range(GROUPS - 1) * PEND_STRIDE
                      + $urandom_range(WORDS_PER_GROUP - 1) * 4);
         if ($urandom_range(3) == 0) r.wdata = '1;
      end else if (pick < 96) begin
         r.op = $urandom_range(1) ? OP_WRITE : OP_READ;
      end else begin
         r.op = OP_NONE;
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_req(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("mismatch in %s at cycle %0d: got %h, expected %h",
               what, cycle_count, got, want);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Prediction on each accepted request, comparison on each accepted response.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            want_rsp = apply_gpio_item(req_data);
            if (fixed_check) begin
               want_rsp.rdata      = fixed_rdata;
               want_rsp.addr_error = fixed_err;
            end
            awaited_rsp.push_back(want_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("response with no transaction outstanding",
                               64'(rsp_data.rdata), '0);
            end else begin
               want_rsp = awaited_rsp.pop_front();
               if (rsp_data.rdata !== want_rsp.rdata)
                  report_mismatch("rdata", 64'(rsp_data.rdata), 64'(want_rsp.rdata));
               if (rsp_data.addr_error !== want_rsp.addr_error)
                  report_mismatch("addr_error", 64'(rsp_data.addr_error),
                                  64'(want_rsp.addr_error));
               if (rsp_data.irq_lines !== want_rsp.irq_lines)
                  report_mismatch("irq_lines", 64'(rsp_data.irq_lines),
                                  64'(want_rsp.irq_lines));
               if (rsp_data.pad_out !== want_rsp.pad_out)
                  report_mismatch("pad_out", rsp_data.pad_out, want_rsp.pad_out);
               if (rsp_data.pad_oe !== want_rsp.pad_oe)
                  report_mismatch("pad_oe", rsp_data.pad_oe, want_rsp.pad_oe);
               if (rsp_data.pad_periph !== want_rsp.pad_periph)
                  report_mismatch("pad_periph", rsp_data.pad_periph, want_rsp.pad_periph);
            end
         end
      end
   end

   initial begin
      int unsigned phase, n;
      foreach (pin_cfg[i]) pin_cfg[i] = '0;
      foreach (pend_word[i]) pend_word[i] = '0;
      last_lv = '0;

      // Reset values, unmapped addresses, every mode, peripheral pins and extremes.
      directed_rows.push_back(dir_row(OP_READ,  12'h000, 32'h0, 64'h0, 1'b1, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h800, 32'h0, 64'h0, 1'b1, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h001, 32'h0, 64'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(dir_row(OP_READ,  12'h100, 32'h0, 64'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(dir_row(OP_READ,  12'h808, 32'h0, 64'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(dir_row(OP_READ,  12'hA00, 32'h0, 64'h0, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(dir_row(OP_WRITE, 12'hFFF, '1, '1, 1'b1, 32'h0, 1'b1));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h000, '1, 64'h0, 1'b1, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h000, 32'h0, 64'h0, 1'b1, 32'h0007_022E,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h0FC, 32'h0007_0004, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h004, 32'h0000_0008, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h008, 32'h0001_000A, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h00C, 32'h0002_000C, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h010, 32'h0003_0006, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h014, 32'h0000_0003, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h018, 32'h0000_0223, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h080, 32'h0004_0024, 64'h0, 1'b0, 32'h0,
                                      1'b0));
      directed_rows.push_back(dir_row(OP_SAMPLE, 12'h0, 32'h0, '1, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_SAMPLE, 12'h0, 32'h0, 64'h0, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h800, 32'h0, 64'h0, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h9C4, 32'h0, 64'h0, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h800, '1, 64'h0, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_READ,  12'h0FC, 32'h0, 64'h0, 1'b0, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_NONE,  12'hFFF, '1, '1, 1'b1, 32'h0, 1'b0));
      directed_rows.push_back(dir_row(OP_WRITE, 12'h000, 32'h0, 64'h0, 1'b1, 32'h0, 1'b0));

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         fixed_check = directed_rows[i].typed;
         fixed_rdata = directed_rows[i].rdata;
         fixed_err   = directed_rows[i].err;
         send_req(directed_rows[i].item);
      end
      fixed_check = 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 24; rsp_stall_pct = 24; end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) send_req(draw_gpio_item());
         // Hold off new requests until every response of this phase is in.
         req_valid <= 1'b0;
         @(negedge clock);
         while (awaited_rsp.size() != 0) @(negedge clock);
      end

      repeat (5) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
